### rtl/bwf_pkg.sv
`default_nettype none

package bwf_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_FRICTION_COEFF = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_EXTENT_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_EXTENT_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_EXTENT_Z   = 3'd4;

    localparam logic [18:0] RST_FRICTION_COEFF = 19'd0;
    localparam logic [30:0] RST_TIME_STEP      = 31'd65536;
    localparam logic [30:0] RST_BOX_EXTENT     = 31'd655360;

    localparam logic [32:0] MAG_CAP = 33'h1_FFFF_FFFF;

    // fields that ride along the whole pipeline
    typedef struct packed {
        logic [2:0]       wall;
        logic [2:0][31:0] vel;
        logic [2:0][31:0] mom;
        logic [2:0][31:0] frc;
        logic [31:0]      np;
        logic [47:0]      rate;
        logic [32:0]      mag;
    } t_side;

    // square root step state
    typedef struct packed {
        logic [63:0] rem;
        logic [31:0] root;
    } t_sq;

    // division by time step, numerator is num * 2^16
    typedef struct packed {
        logic [30:0] rem;
        logic [47:0] quo;
        logic [31:0] num;
    } t_dv;

    // friction component division by the momentum norm
    typedef struct packed {
        logic [31:0] rem;
        logic [32:0] quo;
        logic [63:0] prod;
    } t_fd;

endpackage

`default_nettype wire

### rtl/box_wall_friction_node_update_core.sv
`default_nettype none

// Box wall boundary with Coulomb friction for one 3-D grid node per item, all values Q16.16.
// One item enters per clock while the result side is not stalled; the depth is set by the
// bit-per-stage square roots (32 stages), the divisions by the time step (48 stages) and the
// division by the momentum norm (33 stages). When the result side stalls, the whole pipeline
// holds, and input ready drops until the output register is taken. Configuration registers
// are written through a plain write port and must only change while the pipeline is empty.
module box_wall_friction_node_update_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [bwf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [bwf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [31:0]                i_pos_x,
    input  wire logic signed [31:0]                i_pos_y,
    input  wire logic signed [31:0]                i_pos_z,
    input  wire logic signed [31:0]                i_vel_x,
    input  wire logic signed [31:0]                i_vel_y,
    input  wire logic signed [31:0]                i_vel_z,
    input  wire logic signed [31:0]                i_mom_x,
    input  wire logic signed [31:0]                i_mom_y,
    input  wire logic signed [31:0]                i_mom_z,
    input  wire logic signed [31:0]                i_force_x,
    input  wire logic signed [31:0]                i_force_y,
    input  wire logic signed [31:0]                i_force_z,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [31:0]                     o_new_vel_x,
    output logic signed [31:0]                     o_new_vel_y,
    output logic signed [31:0]                     o_new_vel_z,
    output logic signed [31:0]                     o_new_mom_x,
    output logic signed [31:0]                     o_new_mom_y,
    output logic signed [31:0]                     o_new_mom_z,
    output logic signed [31:0]                     o_new_force_x,
    output logic signed [31:0]                     o_new_force_y,
    output logic signed [31:0]                     o_new_force_z,
    output logic [2:0]                             o_wall_axes
);
    import bwf_pkg::*;

    localparam int SQ_N   = 32;
    localparam int DV_N   = 48;
    localparam int J_N    = 33;
    localparam int ST_SQ0 = 4;
    localparam int ST_DV0 = ST_SQ0 + SQ_N;
    localparam int ST_G   = ST_DV0 + DV_N;
    localparam int ST_H   = ST_G + 1;
    localparam int ST_I   = ST_H + 1;
    localparam int ST_J0  = ST_I + 1;
    localparam int ST_K   = ST_J0 + J_N;
    localparam int NSTG   = ST_K + 1;

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? (32'd0 - v) : v;
        return r;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic t_sq sq_step(input t_sq s, input int unsigned k);
        logic [64:0] trial;
        t_sq         o;
        trial = ({33'd0, s.root} << (k + 1)) + (65'd1 << (2 * k));
        o = s;
        if ({1'b0, s.rem} >= trial) begin
            o.rem  = s.rem - trial[63:0];
            o.root = s.root | (32'd1 << k);
        end
        return o;
    endfunction

    function automatic t_dv dv_step(input t_dv s, input logic nb, input logic [30:0] dv);
        logic [31:0] r2;
        t_dv         o;
        o = s;
        r2 = {s.rem, nb};
        o.quo = {s.quo[46:0], 1'b0};
        if (r2 >= {1'b0, dv}) begin
            r2 = r2 - {1'b0, dv};
            o.quo[0] = 1'b1;
        end
        o.rem = r2[30:0];
        return o;
    endfunction

    function automatic t_fd fd_step(input t_fd s, input logic nb, input logic [31:0] dv);
        logic [32:0] r2;
        t_fd         o;
        o = s;
        r2 = {s.rem, nb};
        o.quo = {s.quo[31:0], 1'b0};
        if (r2 >= {1'b0, dv}) begin
            r2 = r2 - {1'b0, dv};
            o.quo[0] = 1'b1;
        end
        o.rem = r2[31:0];
        return o;
    endfunction

    // configuration registers
    logic [18:0] r_mu;
    logic [30:0] r_dt;
    logic [30:0] r_ext [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu     <= RST_FRICTION_COEFF;
            r_dt     <= RST_TIME_STEP;
            r_ext[0] <= RST_BOX_EXTENT;
            r_ext[1] <= RST_BOX_EXTENT;
            r_ext[2] <= RST_BOX_EXTENT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRICTION_COEFF: r_mu     <= i_cfg_data[18:0];
                CFG_TIME_STEP:      r_dt     <= i_cfg_data;
                CFG_BOX_EXTENT_X:   r_ext[0] <= i_cfg_data;
                CFG_BOX_EXTENT_Y:   r_ext[1] <= i_cfg_data;
                CFG_BOX_EXTENT_Z:   r_ext[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control: every stage advances together
    logic        w_adv;
    logic        r_vld  [NSTG];
    t_side       r_side [NSTG];

    assign w_adv   = i_ready | ~r_vld[NSTG-1];
    assign o_ready = w_adv;
    assign o_valid = r_vld[NSTG-1];

    // stage 0: wall detect, time step times force
    logic signed [31:0] w_pos [3];
    logic signed [31:0] w_vel [3];
    logic signed [31:0] w_mom [3];
    logic signed [31:0] w_frc [3];
    t_side              n_side0;
    logic signed [63:0] n_q   [3];
    logic signed [63:0] r_q   [3];
    logic signed [31:0] r_mom_raw [3];

    assign w_pos = '{i_pos_x, i_pos_y, i_pos_z};
    assign w_vel = '{i_vel_x, i_vel_y, i_vel_z};
    assign w_mom = '{i_mom_x, i_mom_y, i_mom_z};
    assign w_frc = '{i_force_x, i_force_y, i_force_z};

    always_comb begin
        n_side0 = '0;
        for (int a = 0; a < 3; a++) begin
            n_side0.wall[a] = (w_pos[a] == 32'sd0) ||
                              (!w_pos[a][31] && (w_pos[a][30:0] == r_ext[a]));
            n_side0.vel[a]  = n_side0.wall[a] ? 32'd0 : w_vel[a];
            n_side0.mom[a]  = n_side0.wall[a] ? 32'd0 : w_mom[a];
            n_side0.frc[a]  = n_side0.wall[a] ? 32'd0 : w_frc[a];
            n_q[a]          = $signed({1'b0, r_dt}) * w_frc[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= n_side0;
            for (int a = 0; a < 3; a++) begin
                r_q[a]       <= n_q[a];
                r_mom_raw[a] <= w_mom[a];
            end
        end
    end

    // stage 1: removed impulse magnitude on wall axes
    logic [31:0]        n_md [3];
    logic [31:0]        r_md [3];
    logic signed [63:0] w_qt [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_qt[a] = r_q[a] >>> 16;
            // round toward zero
            if (r_q[a][63] && (r_q[a][15:0] != 16'd0)) begin
                w_qt[a] = w_qt[a] + 64'sd1;
            end
            n_md[a] = r_side[0].wall[a] ?
                      abs32($signed(sat32(64'(r_mom_raw[a]) + w_qt[a]))) : 32'd0;
        end
    end

    // stage 2: squares, stage 3: sums
    logic [63:0] r_dsq_t [3];
    logic [63:0] r_psq_t [3];
    logic [63:0] r_dsq;
    logic [63:0] r_psq;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int a = 0; a < 3; a++) begin
                r_md[a]    <= n_md[a];
                r_dsq_t[a] <= r_md[a] * r_md[a];
                r_psq_t[a] <= abs32($signed(r_side[1].mom[a])) *
                              abs32($signed(r_side[1].mom[a]));
            end
            r_dsq <= r_dsq_t[0] + r_dsq_t[1] + r_dsq_t[2];
            r_psq <= r_psq_t[0] + r_psq_t[1] + r_psq_t[2];
        end
    end

    // square roots, one result bit per stage
    t_sq r_sqd [SQ_N];
    t_sq r_sqp [SQ_N];

    for (genvar j = 0; j < SQ_N; j++) begin : g_sq
        t_sq w_src_d;
        t_sq w_src_p;
        t_sq n_sqd;
        t_sq n_sqp;
        if (j == 0) begin : g_first
            assign w_src_d = '{rem: r_dsq, root: 32'd0};
            assign w_src_p = '{rem: r_psq, root: 32'd0};
        end else begin : g_next
            assign w_src_d = r_sqd[j-1];
            assign w_src_p = r_sqp[j-1];
        end
        assign n_sqd = sq_step(w_src_d, SQ_N - 1 - j);
        assign n_sqp = sq_step(w_src_p, SQ_N - 1 - j);
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sqd[j] <= n_sqd;
                r_sqp[j] <= n_sqp;
            end
        end
    end

    // divisions of norm * 2^16 by the time step, one quotient bit per stage
    t_dv r_dvd [DV_N];
    t_dv r_dvp [DV_N];

    for (genvar j = 0; j < DV_N; j++) begin : g_dv
        localparam int BI = DV_N - 1 - j;
        t_dv  w_src_d;
        t_dv  w_src_p;
        t_dv  n_dvd;
        t_dv  n_dvp;
        logic w_nb_d;
        logic w_nb_p;
        if (j == 0) begin : g_first
            assign w_src_d = '{rem: 31'd0, quo: 48'd0, num: r_sqd[SQ_N-1].root};
            assign w_src_p = '{rem: 31'd0, quo: 48'd0, num: r_sqp[SQ_N-1].root};
        end else begin : g_next
            assign w_src_d = r_dvd[j-1];
            assign w_src_p = r_dvp[j-1];
        end
        if (BI >= 16) begin : g_num
            assign w_nb_d = w_src_d.num[BI-16];
            assign w_nb_p = w_src_p.num[BI-16];
        end else begin : g_zero
            assign w_nb_d = 1'b0;
            assign w_nb_p = 1'b0;
        end
        assign n_dvd = dv_step(w_src_d, w_nb_d, r_dt);
        assign n_dvp = dv_step(w_src_p, w_nb_p, r_dt);
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dvd[j] <= n_dvd;
                r_dvp[j] <= n_dvp;
            end
        end
    end

    // friction limit mu * fn, then the clamped magnitude
    logic [31:0] w_fn;
    logic [50:0] r_lim_full;
    logic [47:0] w_lim;
    logic [47:0] w_m48;
    logic [32:0] n_mag;

    assign w_fn  = (r_dvd[DV_N-1].quo[47:32] != 16'd0) ? 32'hFFFF_FFFF
                                                       : r_dvd[DV_N-1].quo[31:0];
    assign w_lim = {13'd0, r_lim_full[50:16]};
    assign w_m48 = (r_side[ST_G].rate < w_lim) ? r_side[ST_G].rate : w_lim;
    assign n_mag = (w_m48[47:33] != 15'd0) ? MAG_CAP : w_m48[32:0];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lim_full <= r_mu * w_fn;
        end
    end

    // friction share per axis: mag * |p_a|, then divided by |p|
    logic [63:0] r_prod [3];
    t_fd         r_fd   [J_N][3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int a = 0; a < 3; a++) begin
                r_prod[a] <= 64'(r_side[ST_H].mag * abs32($signed(r_side[ST_H].mom[a])));
            end
        end
    end

    for (genvar j = 0; j < J_N; j++) begin : g_fd
        for (genvar a = 0; a < 3; a++) begin : g_lane
            t_fd w_src;
            t_fd n_fd;
            if (j == 0) begin : g_first
                assign w_src = '{rem: {1'b0, r_prod[a][63:33]}, quo: 33'd0,
                                 prod: r_prod[a]};
            end else begin : g_next
                assign w_src = r_fd[j-1][a];
            end
            assign n_fd = fd_step(w_src, w_src.prod[J_N-1-j], r_side[ST_J0+j-1].np);
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_fd[j][a] <= n_fd;
                end
            end
        end
    end

    // apply friction against momentum direction, saturate
    logic [31:0]        r_frc_out [3];
    logic [31:0]        n_frc_out [3];
    logic [32:0]        w_c       [3];
    logic signed [63:0] w_fsum    [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_c[a] = (r_side[ST_K-1].np != 32'd0) ? r_fd[J_N-1][a].quo : 33'd0;
            if (r_side[ST_K-1].mom[a][31]) begin
                w_fsum[a] = 64'($signed(r_side[ST_K-1].frc[a])) + 64'(w_c[a]);
            end else begin
                w_fsum[a] = 64'($signed(r_side[ST_K-1].frc[a])) - 64'(w_c[a]);
            end
            n_frc_out[a] = sat32(w_fsum[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int a = 0; a < 3; a++) begin
                r_frc_out[a] <= n_frc_out[a];
            end
        end
    end

    // valid bits and carried fields
    for (genvar s = 1; s < NSTG; s++) begin : g_stage
        t_side n_side;
        always_comb begin
            n_side = r_side[s-1];
            if (s == ST_DV0) begin
                n_side.np = r_sqp[SQ_N-1].root;
            end
            if (s == ST_G) begin
                n_side.rate = r_dvp[DV_N-1].quo;
            end
            if (s == ST_H) begin
                n_side.mag = n_mag;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (w_adv) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_side[s] <= n_side;
            end
        end
    end

    assign o_new_vel_x   = r_side[NSTG-1].vel[0];
    assign o_new_vel_y   = r_side[NSTG-1].vel[1];
    assign o_new_vel_z   = r_side[NSTG-1].vel[2];
    assign o_new_mom_x   = r_side[NSTG-1].mom[0];
    assign o_new_mom_y   = r_side[NSTG-1].mom[1];
    assign o_new_mom_z   = r_side[NSTG-1].mom[2];
    assign o_new_force_x = r_frc_out[0];
    assign o_new_force_y = r_frc_out[1];
    assign o_new_force_z = r_frc_out[2];
    assign o_wall_axes   = r_side[NSTG-1].wall;

endmodule

`default_nettype wire
